@@ hdl/radial_point_force_impulse_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the radial point force block
// Immediate-implication and next-cycle checks on the block clock.
// ----------------------------------------------------------------------------
`ifndef RADIAL_POINT_FORCE_IMPULSE_MACROS_SVH
`define RADIAL_POINT_FORCE_IMPULSE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPFI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RPFI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/rpfi_pkg.sv @@
// ----------------------------------------------------------------------------
// rpfi_pkg
// Types and constants shared by the radial point force pipeline.
// ----------------------------------------------------------------------------
package rpfi_pkg;

  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 17;
  localparam int unsigned NumLanes  = 3;

  localparam int unsigned LaneX = 0;
  localparam int unsigned LaneY = 1;
  localparam int unsigned LaneF = 2;

  localparam logic [2:0] RegTouchX   = 3'd0;
  localparam logic [2:0] RegTouchY   = 3'd1;
  localparam logic [2:0] RegRadius   = 3'd2;
  localparam logic [2:0] RegStrength = 3'd3;
  localparam logic [2:0] RegRepulse  = 3'd4;

  localparam logic [30:0] RadiusReset = 31'd65536;
  localparam logic [63:0] NearZeroD2  = 64'd43;
  localparam logic [16:0] QuotMax     = 17'd65536;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               last;
    logic               hit;
    logic               neg_x;
    logic               neg_y;
  } base_t;

  typedef struct packed {
    base_t       base;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [63:0] d2sh;
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    base_t                          base;
    logic [NumLanes-1:0][47:0]      rem;
    logic [NumLanes-1:0][46:0]      dsh;
    logic [NumLanes-1:0][16:0]      q;
  } div_t;

endpackage

@@ hdl/rpfi_in_if.sv @@
// ----------------------------------------------------------------------------
// rpfi_in_if
// Particle channel: position, velocity and batch end marker.
// ----------------------------------------------------------------------------
interface rpfi_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic               last_in;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, last_in, input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, last_in, output ready);
endinterface

@@ hdl/rpfi_out_if.sv @@
// ----------------------------------------------------------------------------
// rpfi_out_if
// Result channel: updated velocity, affected flag and batch end marker.
// ----------------------------------------------------------------------------
interface rpfi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  logic               affected;
  logic               last_out;

  modport source (output valid, new_vel_x, new_vel_y, affected, last_out, input ready);
  modport sink (input valid, new_vel_x, new_vel_y, affected, last_out, output ready);
endinterface

@@ hdl/rpfi_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// rpfi_sqrt_cell
// One restoring square root step: consumes two radicand bits per cell.
// ----------------------------------------------------------------------------
module rpfi_sqrt_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rpfi_pkg::sqrt_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rpfi_pkg::sqrt_t out_data
);

  logic            valid;
  rpfi_pkg::sqrt_t data;
  rpfi_pkg::sqrt_t data_next;
  logic [35:0]     rs;
  logic [35:0]     trial;
  logic            fits;

  always_comb begin
    rs    = {in_data.rem, in_data.d2sh[63:62]};
    trial = {2'b00, in_data.root, 2'b01};
    fits  = (rs >= trial);
    data_next      = in_data;
    data_next.d2sh = {in_data.d2sh[61:0], 2'b00};
    data_next.rem  = fits ? 34'(rs - trial) : rs[33:0];
    data_next.root = {in_data.root[30:0], fits};
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

@@ hdl/rpfi_div_cell.sv @@
// ----------------------------------------------------------------------------
// rpfi_div_cell
// One restoring division step on three lanes (x unit, y unit, falloff).
// ----------------------------------------------------------------------------
module rpfi_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rpfi_pkg::div_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rpfi_pkg::div_t out_data
);

  logic                            valid;
  rpfi_pkg::div_t                  data;
  rpfi_pkg::div_t                  data_next;
  logic [rpfi_pkg::NumLanes-1:0]   ge;

  always_comb begin
    data_next = in_data;
    for (int i = 0; i < rpfi_pkg::NumLanes; i++) begin
      ge[i] = (in_data.rem[i] >= {1'b0, in_data.dsh[i]});
      data_next.rem[i] = ge[i] ? (in_data.rem[i] - {1'b0, in_data.dsh[i]}) : in_data.rem[i];
      data_next.dsh[i] = in_data.dsh[i] >> 1;
      data_next.q[i]   = {in_data.q[i][15:0], ge[i]};
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

@@ hdl/radial_point_force_impulse.sv @@
// ----------------------------------------------------------------------------
// radial_point_force_impulse
// Radial point force with linear falloff applied to a stream of particles.
// ----------------------------------------------------------------------------
// Throughput: one particle per cycle while result.ready holds; every stage is
// a valid/ready cell, so bubbles collapse and stalls only back up as far as
// needed.
// Depth is set by the 32 square root cells and 17 divider cells.
// Reset clears all stage valids and loads the register reset values.
// ----------------------------------------------------------------------------
`include "radial_point_force_impulse_macros.svh"

module radial_point_force_impulse (
  input  logic        clk,
  input  logic        rst,
  rpfi_in_if.sink     particle,
  rpfi_out_if.source  result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration
  logic signed [31:0] touch_x;
  logic signed [31:0] touch_y;
  logic [30:0]        force_radius;
  logic [30:0]        force_strength;
  logic               repulse_mode;
  logic [61:0]        r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      touch_x        <= '0;
      touch_y        <= '0;
      force_radius   <= rpfi_pkg::RadiusReset;
      force_strength <= '0;
      repulse_mode   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        rpfi_pkg::RegTouchX:   touch_x        <= cfg_data;
        rpfi_pkg::RegTouchY:   touch_y        <= cfg_data;
        rpfi_pkg::RegRadius:   force_radius   <= cfg_data[30:0];
        rpfi_pkg::RegStrength: force_strength <= cfg_data[30:0];
        rpfi_pkg::RegRepulse:  repulse_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r2 <= force_radius * force_radius;
  end

  // stage 0: differences and magnitudes
  logic               s0_v, s0_rdy;
  rpfi_pkg::base_t    s0_b;
  logic [31:0]        s0_ax, s0_ay;
  logic signed [32:0] dx, dy;

  // stage 1: squares
  logic               s1_v, s1_rdy;
  rpfi_pkg::base_t    s1_b;
  logic [31:0]        s1_ax, s1_ay;
  logic [63:0]        s1_ax2, s1_ay2;

  // stage 2 feeds the root chain
  logic               s2_rdy;
  logic [64:0]        d2_sum;
  logic               s2_hit;
  rpfi_pkg::base_t    s2_b;

  logic                 sqrt_valid [0:rpfi_pkg::SqrtSteps];
  logic                 sqrt_rdy   [0:rpfi_pkg::SqrtSteps];
  rpfi_pkg::sqrt_t      sqrt_data  [0:rpfi_pkg::SqrtSteps];

  logic                 div_valid [0:rpfi_pkg::DivSteps];
  logic                 div_rdy   [0:rpfi_pkg::DivSteps];
  rpfi_pkg::div_t       div_data  [0:rpfi_pkg::DivSteps];

  logic               s3_rdy;
  logic [30:0]        root_dist;

  logic               s4_v, s4_rdy;
  rpfi_pkg::base_t    s4_b;
  logic [31:0]        s4_mx, s4_my;
  logic [16:0]        s4_qf;
  logic [47:0]        prod_x, prod_y;

  logic               s5_v, s5_rdy;
  rpfi_pkg::base_t    s5_b;
  logic [32:0]        s5_mx, s5_my;
  logic [48:0]        prod2_x, prod2_y;

  logic               out_v, out_rdy;
  logic signed [31:0] out_vx, out_vy;
  logic               out_hit, out_last;
  logic signed [33:0] sum_x, sum_y;
  logic signed [31:0] sat_x, sat_y;

  assign particle.ready = s0_rdy;
  assign s0_rdy = !s0_v || s1_rdy;
  assign s1_rdy = !s1_v || s2_rdy;
  assign s2_rdy = !sqrt_valid[0] || sqrt_rdy[0];
  assign s3_rdy = !div_valid[0] || div_rdy[0];
  assign s4_rdy = !s4_v || s5_rdy;
  assign s5_rdy = !s5_v || out_rdy;
  assign out_rdy = !out_v || result.ready;

  assign dx = 33'(touch_x) - 33'(particle.pos_x);
  assign dy = 33'(touch_y) - 33'(particle.pos_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (s0_rdy) begin
      s0_v <= particle.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_rdy && particle.valid) begin
      s0_b.vel_x <= particle.vel_x;
      s0_b.vel_y <= particle.vel_y;
      s0_b.last  <= particle.last_in;
      s0_b.hit   <= 1'b0;
      s0_b.neg_x <= dx[32] ^ repulse_mode;
      s0_b.neg_y <= dy[32] ^ repulse_mode;
      s0_ax      <= dx[32] ? 32'(-dx) : dx[31:0];
      s0_ay      <= dy[32] ? 32'(-dy) : dy[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_rdy) begin
      s1_v <= s0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && s0_v) begin
      s1_b   <= s0_b;
      s1_ax  <= s0_ax;
      s1_ay  <= s0_ay;
      s1_ax2 <= s0_ax * s0_ax;
      s1_ay2 <= s0_ay * s0_ay;
    end
  end

  // a sum past 64 bits counts as outside the radius
  assign d2_sum = {1'b0, s1_ax2} + {1'b0, s1_ay2};
  assign s2_hit = !d2_sum[64] && (d2_sum[63:0] <= {2'b00, r2}) &&
                  (d2_sum[63:0] >= rpfi_pkg::NearZeroD2);

  always_comb begin
    s2_b     = s1_b;
    s2_b.hit = s2_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sqrt_valid[0] <= 1'b0;
    end else if (s2_rdy) begin
      sqrt_valid[0] <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_v) begin
      sqrt_data[0].base     <= s2_b;
      sqrt_data[0].ax       <= s1_ax;
      sqrt_data[0].ay       <= s1_ay;
      sqrt_data[0].d2sh     <= d2_sum[63:0];
      sqrt_data[0].rem      <= '0;
      sqrt_data[0].root     <= '0;
    end
  end

  for (genvar i = 0; i < rpfi_pkg::SqrtSteps; i++) begin : g_sqrt
    rpfi_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sqrt_valid[i]),
      .in_ready  (sqrt_rdy[i]),
      .in_data   (sqrt_data[i]),
      .out_valid (sqrt_valid[i+1]),
      .out_ready (sqrt_rdy[i+1]),
      .out_data  (sqrt_data[i+1])
    );
  end

  assign sqrt_rdy[rpfi_pkg::SqrtSteps] = s3_rdy;

  // stage 3: set up the three divisions
  assign root_dist = sqrt_data[rpfi_pkg::SqrtSteps].root[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_valid[0] <= 1'b0;
    end else if (s3_rdy) begin
      div_valid[0] <= sqrt_valid[rpfi_pkg::SqrtSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && sqrt_valid[rpfi_pkg::SqrtSteps]) begin
      div_data[0].base <= sqrt_data[rpfi_pkg::SqrtSteps].base;
      div_data[0].rem[rpfi_pkg::LaneX] <=
        {1'b0, sqrt_data[rpfi_pkg::SqrtSteps].ax[30:0], 16'd0};
      div_data[0].rem[rpfi_pkg::LaneY] <=
        {1'b0, sqrt_data[rpfi_pkg::SqrtSteps].ay[30:0], 16'd0};
      div_data[0].rem[rpfi_pkg::LaneF] <= {1'b0, 31'(force_radius - root_dist), 16'd0};
      div_data[0].dsh[rpfi_pkg::LaneX] <= {root_dist, 16'd0};
      div_data[0].dsh[rpfi_pkg::LaneY] <= {root_dist, 16'd0};
      div_data[0].dsh[rpfi_pkg::LaneF] <= {force_radius, 16'd0};
      div_data[0].q <= '0;
    end
  end

  for (genvar i = 0; i < rpfi_pkg::DivSteps; i++) begin : g_div
    rpfi_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (div_valid[i]),
      .in_ready  (div_rdy[i]),
      .in_data   (div_data[i]),
      .out_valid (div_valid[i+1]),
      .out_ready (div_rdy[i+1]),
      .out_data  (div_data[i+1])
    );
  end

  assign div_rdy[rpfi_pkg::DivSteps] = s4_rdy;

  // stage 4: unit component times strength
  assign prod_x = div_data[rpfi_pkg::DivSteps].q[rpfi_pkg::LaneX] * force_strength;
  assign prod_y = div_data[rpfi_pkg::DivSteps].q[rpfi_pkg::LaneY] * force_strength;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (s4_rdy) begin
      s4_v <= div_valid[rpfi_pkg::DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (s4_rdy && div_valid[rpfi_pkg::DivSteps]) begin
      s4_b  <= div_data[rpfi_pkg::DivSteps].base;
      s4_mx <= prod_x[47:16];
      s4_my <= prod_y[47:16];
      s4_qf <= div_data[rpfi_pkg::DivSteps].q[rpfi_pkg::LaneF];
    end
  end

  // stage 5: times falloff
  assign prod2_x = s4_mx * s4_qf;
  assign prod2_y = s4_my * s4_qf;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (s5_rdy) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_rdy && s4_v) begin
      s5_b  <= s4_b;
      s5_mx <= prod2_x[48:16];
      s5_my <= prod2_y[48:16];
    end
  end

  // output register: signed add and saturate; particles without a hit keep their velocity
  always_comb begin
    sum_x = s5_b.neg_x ? (34'(s5_b.vel_x) - $signed({1'b0, s5_mx}))
                       : (34'(s5_b.vel_x) + $signed({1'b0, s5_mx}));
    sum_y = s5_b.neg_y ? (34'(s5_b.vel_y) - $signed({1'b0, s5_my}))
                       : (34'(s5_b.vel_y) + $signed({1'b0, s5_my}));
    if (sum_x > 34'sd2147483647) begin
      sat_x = 32'sh7fffffff;
    end else if (sum_x < -34'sd2147483648) begin
      sat_x = 32'sh80000000;
    end else begin
      sat_x = sum_x[31:0];
    end
    if (sum_y > 34'sd2147483647) begin
      sat_y = 32'sh7fffffff;
    end else if (sum_y < -34'sd2147483648) begin
      sat_y = 32'sh80000000;
    end else begin
      sat_y = sum_y[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_rdy) begin
      out_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && s5_v) begin
      out_vx   <= s5_b.hit ? sat_x : s5_b.vel_x;
      out_vy   <= s5_b.hit ? sat_y : s5_b.vel_y;
      out_hit  <= s5_b.hit;
      out_last <= s5_b.last;
    end
  end

  assign result.valid     = out_v;
  assign result.new_vel_x = out_vx;
  assign result.new_vel_y = out_vy;
  assign result.affected  = out_hit;
  assign result.last_out  = out_last;

  `RPFI_ASSERT_NOW(a_dist_range, sqrt_valid[rpfi_pkg::SqrtSteps] && sqrt_data[rpfi_pkg::SqrtSteps].base.hit, sqrt_data[rpfi_pkg::SqrtSteps].root[31] == 1'b0, "distance exceeds radius width")
  `RPFI_ASSERT_NOW(a_quot_range, div_valid[rpfi_pkg::DivSteps] && div_data[rpfi_pkg::DivSteps].base.hit, (div_data[rpfi_pkg::DivSteps].q[rpfi_pkg::LaneX] <= rpfi_pkg::QuotMax) && (div_data[rpfi_pkg::DivSteps].q[rpfi_pkg::LaneF] <= rpfi_pkg::QuotMax), "quotient out of range")
  `RPFI_ASSERT_NEXT(a_stage_hold, s0_v && !s1_rdy, s0_v, "stalled transaction dropped at stage 0")

endmodule
